// ===== hw/rtl/iol_pkg.sv =====
// iol_pkg: shared types and codes for the indexed ordered list
// request and result payloads, command and status codes, cell control
// no dependencies
package iol_pkg;

  localparam int unsigned DefaultDepth      = 64;
  localparam int unsigned DefaultValueWidth = 32;

  // request commands
  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_AT   = 3'd2,
    CMD_DEL_HEAD = 3'd3,
    CMD_DEL_TAIL = 3'd4,
    CMD_DEL_AT   = 3'd5,
    CMD_READ_AT  = 3'd6,
    CMD_LOOKUP   = 3'd7
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [6:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               found;
    logic [6:0]         count;
  } res_t;

  // per-cycle control broadcast to every cell of the row
  typedef struct packed {
    logic ins;     // shift up from the selected position, write new value there
    logic del;     // shift down onto the selected position
    logic rd;      // the selected cell drives its entry onto the read bus
    logic lookup;  // live cells compare against the request value
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/iol_cell.sv =====
// iol_cell: one entry of the shifting list row
// takes from its left or right neighbor on insert or delete, reports match and read data
// depends on iol_pkg
module iol_cell import iol_pkg::*; #(
  parameter int unsigned Index      = 0,
  parameter int unsigned ValueWidth = DefaultValueWidth,
  parameter int unsigned IdxWidth   = 6,
  parameter int unsigned CntWidth   = 7
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [IdxWidth-1:0]   pos_i,
  input  logic [CntWidth-1:0]   count_i,
  input  logic [ValueWidth-1:0] wr_value_i,
  input  logic [ValueWidth-1:0] left_i,
  input  logic [ValueWidth-1:0] right_i,
  output logic [ValueWidth-1:0] entry_o,
  output logic                  match_o,
  output logic [ValueWidth-1:0] rd_o
);

  localparam logic [IdxWidth-1:0] MyIdx = IdxWidth'(Index);
  localparam logic [CntWidth-1:0] MyCnt = CntWidth'(Index);

  logic [ValueWidth-1:0] entry_d, entry_q;
  logic                  live;

  assign live = (MyCnt < count_i);

  // neighbor selection for insert and delete
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (MyIdx > pos_i) begin
        entry_d = left_i;
      end else if (MyIdx == pos_i) begin
        entry_d = wr_value_i;
      end
    end else if (ctrl_i.del && (MyIdx >= pos_i)) begin
      entry_d = right_i;
    end
  end

  // entry storage, no reset: only live entries are ever read
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = ctrl_i.lookup && live && (entry_q == wr_value_i);
  assign rd_o    = (ctrl_i.rd && (MyIdx == pos_i)) ? entry_q : '0;

endmodule

// ===== hw/rtl/iol_ctrl.sv =====
// iol_ctrl: request decode for the list row
// checks bounds against the length, picks the position and the next length
// depends on iol_pkg
module iol_ctrl import iol_pkg::*; #(
  parameter int unsigned Depth    = DefaultDepth,
  parameter int unsigned IdxWidth = 6,
  parameter int unsigned CntWidth = 7
) (
  input  req_t                req_i,
  input  logic                start_i,
  input  logic [CntWidth-1:0] count_i,
  output cell_ctrl_t          ctrl_o,
  output logic [IdxWidth-1:0] pos_o,
  output logic [1:0]          status_o,
  output logic [CntWidth-1:0] count_d_o
);

  localparam int unsigned CmpWidth = (CntWidth > 7) ? CntWidth : 7;
  localparam logic [CmpWidth-1:0] DepthC = CmpWidth'(Depth);

  logic [CmpWidth-1:0] cnt_ext, pos_ext, pos_sel;
  logic                full, empty;

  assign cnt_ext = CmpWidth'(count_i);
  assign pos_ext = CmpWidth'(req_i.position);
  assign full    = (cnt_ext >= DepthC);
  assign empty   = (count_i == '0);

  // command decode and bounds checks
  always_comb begin
    ctrl_o   = '0;
    status_o = ST_OK;
    pos_sel  = pos_ext;
    case (req_i.cmd) inside
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
        if (req_i.cmd == CMD_INS_HEAD) begin
          pos_sel = '0;
        end else if (req_i.cmd == CMD_INS_TAIL) begin
          pos_sel = cnt_ext;
        end
        if (full) begin
          status_o = ST_FULL;
        end else if (pos_sel > cnt_ext) begin
          status_o = ST_RANGE;
        end else begin
          ctrl_o.ins = start_i;
        end
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT: begin
        if (req_i.cmd == CMD_DEL_HEAD) begin
          pos_sel = '0;
        end else if (req_i.cmd == CMD_DEL_TAIL) begin
          pos_sel = cnt_ext - CmpWidth'(1);
        end
        if (empty) begin
          status_o = ST_EMPTY;
        end else if (pos_sel >= cnt_ext) begin
          status_o = ST_RANGE;
        end else begin
          ctrl_o.del = start_i;
        end
      end
      CMD_READ_AT: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else if (pos_sel >= cnt_ext) begin
          status_o = ST_RANGE;
        end else begin
          ctrl_o.rd = 1'b1;
        end
      end
      default: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          ctrl_o.lookup = 1'b1;
        end
      end
    endcase
  end

  // position is only used when it lies inside the row
  assign pos_o = pos_sel[IdxWidth-1:0];

  // next length
  always_comb begin
    count_d_o = count_i;
    if (ctrl_o.ins) begin
      count_d_o = count_i + CntWidth'(1);
    end else if (ctrl_o.del) begin
      count_d_o = count_i - CntWidth'(1);
    end
  end

endmodule

// ===== hw/rtl/indexed_ordered_list.sv =====
// indexed_ordered_list: ordered list kept in a row of shifting cells
// request decode, the cell row, read and match collection, result register
// depends on iol_pkg, iol_ctrl, iol_cell
//
// Usage: a request (cmd, value, position) on req_i is transferred at a rising
// clock edge where start_i is high and busy_o is low. busy_o is always low:
// every request finishes in the cycle it is taken, so one request can be sent
// each cycle. Inserts and deletes shift the cells from the position up at once; reads
// and lookups are collected from all cells combinationally.
// Result: res_o is registered, valid in the cycle after the transfer, marked by
// done_o for exactly one cycle. The receiver cannot stall; results are not held.
// Throughput: one request per cycle, since the cell row and the length register
// are both updated at the transfer edge.
// Reset: rst_ni clears the length and the result strobe; cell contents are
// not cleared since only entries below the length are ever read.
// Results carry status, read value, found flag and the length after the request.
module indexed_ordered_list import iol_pkg::*; #(
  parameter int unsigned DEPTH       = DefaultDepth,
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned IdxWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam int unsigned VW       = VALUE_WIDTH;

  logic [CntWidth-1:0] count_q, count_d;
  cell_ctrl_t          ctrl;
  logic [IdxWidth-1:0] pos;
  logic [1:0]          status;
  logic [VW-1:0]       wr_value;
  logic [VW-1:0]       entry [DEPTH];
  logic [VW-1:0]       rd_word [DEPTH];
  logic [DEPTH-1:0]    match;
  logic [VW-1:0]       rd_any;
  logic [31:0]         rd_ext;
  logic                accept;
  res_t                res_d, res_q;
  logic                done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // request value kept to the stored width
  generate
    if (VW <= 32) begin : g_val_trunc
      assign wr_value = req_i.value[VW-1:0];
    end else begin : g_val_zext
      assign wr_value = {{(VW-32){1'b0}}, req_i.value};
    end
  endgenerate

  iol_ctrl #(
    .Depth    (DEPTH),
    .IdxWidth (IdxWidth),
    .CntWidth (CntWidth)
  ) u_ctrl (
    .req_i     (req_i),
    .start_i   (accept),
    .count_i   (count_q),
    .ctrl_o    (ctrl),
    .pos_o     (pos),
    .status_o  (status),
    .count_d_o (count_d)
  );

  // row of cells, each wired to its neighbors
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VW-1:0] left_val, right_val;
      if (i == 0) begin : g_first
        assign left_val = wr_value;
      end else begin : g_mid_l
        assign left_val = entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_val = entry[i];
      end else begin : g_mid_r
        assign right_val = entry[i+1];
      end
      iol_cell #(
        .Index      (i),
        .ValueWidth (VW),
        .IdxWidth   (IdxWidth),
        .CntWidth   (CntWidth)
      ) u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .pos_i      (pos),
        .count_i    (count_q),
        .wr_value_i (wr_value),
        .left_i     (left_val),
        .right_i    (right_val),
        .entry_o    (entry[i]),
        .match_o    (match[i]),
        .rd_o       (rd_word[i])
      );
    end
  endgenerate

  // read bus: at most one cell drives a nonzero word
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | rd_word[i];
    end
  end

  // sign extend or truncate the stored value to the result width
  generate
    if (VW >= 32) begin : g_rd_trunc
      assign rd_ext = rd_any[31:0];
    end else begin : g_rd_sext
      assign rd_ext = {{(32-VW){rd_any[VW-1]}}, rd_any};
    end
  endgenerate

  always_comb begin
    res_d.status     = status;
    res_d.read_value = rd_ext;
    res_d.found      = |match;
    res_d.count      = 7'(count_d);
  end

  // length and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // every transfer gives exactly one result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> done_o)
    else $error("request without result");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !accept |=> !done_o)
    else $error("result without request");
  // length stays within the row
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntWidth'(DEPTH))
    else $error("length beyond depth");
  // a rejected request leaves the length unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status != ST_OK) |=> (count_q == $past(count_q)))
    else $error("rejected request changed length");
  // full status only when the row is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status == ST_FULL) |-> (count_q == CntWidth'(DEPTH)))
    else $error("full status on a list that is not full");

endmodule

// ===== test/iol_checker.sv =====
`timescale 1ns / 100ps
// iol_checker: watches the request and result channels of the ordered list,
// predicts each result from its own copy of the list and compares them
// depends on iol_pkg
module iol_checker import iol_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic done_i,
  input  res_t res_i,
  output int   errors_o,
  output int   pending_o,
  output int   length_o
);

  // own copy of the list contents and length
  logic signed [31:0] list_mem [DEPTH+1];
  int unsigned        list_len;
  res_t               expected_q [$];

  assign length_o  = list_len;

  // apply one request to the list copy and build its result
  task automatic apply_request(input req_t r, output res_t exp);
    int unsigned p;
    int unsigned i;
    p = r.position;
    exp = '0;
    exp.status = ST_OK;
    case (r.cmd)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
        if (list_len >= DEPTH) begin
          exp.status = ST_FULL;
        end else if (r.cmd == CMD_INS_AT && p > list_len) begin
          exp.status = ST_RANGE;
        end else begin
          if (r.cmd == CMD_INS_HEAD) p = 0;
          else if (r.cmd == CMD_INS_TAIL) p = list_len;
          for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = r.value;
          list_len++;
        end
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT: begin
        if (list_len == 0) begin
          exp.status = ST_EMPTY;
        end else if (r.cmd == CMD_DEL_AT && p >= list_len) begin
          exp.status = ST_RANGE;
        end else begin
          if (r.cmd == CMD_DEL_HEAD) p = 0;
          else if (r.cmd == CMD_DEL_TAIL) p = list_len - 1;
          for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      CMD_READ_AT: begin
        if (list_len == 0) exp.status = ST_EMPTY;
        else if (p >= list_len) exp.status = ST_RANGE;
        else exp.read_value = list_mem[p];
      end
      default: begin
        // lookup scans live entries only
        if (list_len == 0) begin
          exp.status = ST_EMPTY;
        end else begin
          for (i = 0; i < list_len; i++) begin
            if (list_mem[i] == r.value) exp.found = 1'b1;
          end
        end
      end
    endcase
    exp.count = list_len[6:0];
  endtask

  // compare one result against the oldest expectation
  task automatic check_result(input res_t got);
    res_t exp;
    if (expected_q.size() == 0) begin
      $display("%0t: result with nothing expected: status %0d read %h found %0d count %0d",
               $realtime, got.status, got.read_value, got.found, got.count);
      errors_o++;
    end else begin
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $realtime, exp.status, got.status);
        errors_o++;
      end
      if (got.read_value !== exp.read_value) begin
        $display("%0t: read_value mismatch: expected %h actual %h",
                 $realtime, exp.read_value, got.read_value);
        errors_o++;
      end
      if (got.found !== exp.found) begin
        $display("%0t: found mismatch: expected %0d actual %0d",
                 $realtime, exp.found, got.found);
        errors_o++;
      end
      if (got.count !== exp.count) begin
        $display("%0t: count mismatch: expected %0d actual %0d",
                 $realtime, exp.count, got.count);
        errors_o++;
      end
    end
  endtask

  // results first, then the request transferred at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp;
    if (!rst_ni) begin
      list_len = 0;
      errors_o = 0;
      expected_q.delete();
    end else begin
      if (done_i) check_result(res_i);
      if (start_i && !busy_i) begin
        apply_request(req_i, exp);
        expected_q.push_back(exp);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// tb: stimulus and verdict for the indexed ordered list
// depends on iol_pkg, indexed_ordered_list and iol_checker
module tb;
  import iol_pkg::*;

  localparam int unsigned DEPTH    = DefaultDepth;
  localparam int          WDOG_MAX = 2000;

  // command mix of one random stretch
  typedef enum {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_e;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic done_o;
  res_t res_o;

  int errors;
  int pending;
  int list_length;
  int idle_pct;
  int quiet_cycles = 0;

  indexed_ordered_list u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  iol_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_i    (busy_o),
    .req_i     (req_i),
    .done_i    (done_o),
    .res_i     (res_o),
    .errors_o  (errors),
    .pending_o (pending),
    .length_o  (list_length)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: cycles without any transfer or result
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request transfer, with random idle cycles ahead of it
  task automatic send_request(input cmd_e cmd, input logic signed [31:0] value,
                              input logic [6:0] position);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    req_i.cmd      <= cmd;
    req_i.value    <= value;
    req_i.position <= position;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // values from a small pool so lookups hit often, else fully random
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] pool [8];
    pool = '{32'sh0, -32'sd1, 32'sh7fffffff, 32'sh80000000,
             32'sd1, 32'sh55555555, 32'shaaaaaaaa, 32'sh12345678};
    if ($urandom_range(99) < 45) return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // positions mostly within the current length, sometimes anywhere
  function automatic logic [6:0] pick_position();
    if ($urandom_range(99) < 75) return 7'($urandom_range(0, list_length));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic cmd_e pick_cmd(input trend_e trend);
    int r;
    int ins_w;
    int del_w;
    r = $urandom_range(99);
    case (trend)
      TREND_GROW:   begin ins_w = 85; del_w = 5;  end
      TREND_SHRINK: begin ins_w = 5;  del_w = 80; end
      default:      begin ins_w = 35; del_w = 30; end
    endcase
    if (r < ins_w) return cmd_e'($urandom_range(CMD_INS_HEAD, CMD_INS_AT));
    if (r < ins_w + del_w) return cmd_e'($urandom_range(CMD_DEL_HEAD, CMD_DEL_AT));
    return ($urandom_range(1)) ? CMD_READ_AT : CMD_LOOKUP;
  endfunction

  task automatic run_stretch(input trend_e trend, input int idle, input int n);
    idle_pct = idle;
    repeat (n) send_request(pick_cmd(trend), pick_value(), pick_position());
  endtask

  initial begin
    idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list cases, extremes, every command
    idle_pct = 35;
    send_request(CMD_DEL_HEAD, 32'sd0, 7'd0);
    send_request(CMD_DEL_TAIL, 32'sd0, 7'd0);
    send_request(CMD_DEL_AT,   32'sd0, 7'd0);
    send_request(CMD_READ_AT,  32'sd0, 7'd0);
    send_request(CMD_LOOKUP,   32'sd0, 7'd0);
    send_request(CMD_INS_AT,   32'sd5, 7'd1);
    send_request(CMD_INS_AT,   32'sd5, 7'd127);
    send_request(CMD_INS_HEAD, 32'sh7fffffff, 7'd0);
    send_request(CMD_INS_TAIL, 32'sh80000000, 7'd127);
    send_request(CMD_INS_AT,   32'sd0, 7'd1);
    send_request(CMD_INS_AT,   -32'sd1, 7'd3);
    send_request(CMD_READ_AT,  32'sd0, 7'd0);
    send_request(CMD_READ_AT,  32'sd0, 7'd1);
    send_request(CMD_READ_AT,  32'sd0, 7'd2);
    send_request(CMD_READ_AT,  32'sd0, 7'd3);
    send_request(CMD_READ_AT,  32'sd0, 7'd4);
    send_request(CMD_READ_AT,  32'sd0, 7'd127);
    send_request(CMD_LOOKUP,   32'sh80000000, 7'd0);
    send_request(CMD_LOOKUP,   32'sh12345, 7'd0);
    send_request(CMD_DEL_AT,   32'sd0, 7'd4);
    send_request(CMD_DEL_AT,   32'sd0, 7'd1);
    send_request(CMD_DEL_TAIL, 32'sd0, 7'd0);
    send_request(CMD_DEL_HEAD, 32'sd0, 7'd0);
    send_request(CMD_DEL_AT,   32'sd0, 7'd0);

    // random: fill past full, churn, drain past empty, under varied idling
    run_stretch(TREND_GROW,   0,  70);
    run_stretch(TREND_MIXED,  86, 60);
    run_stretch(TREND_SHRINK, 35, 80);
    run_stretch(TREND_MIXED,  0,  60);
    run_stretch(TREND_GROW,   35, 70);
    run_stretch(TREND_SHRINK, 86, 60);

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== indexed_ordered_list.f =====
hw/rtl/iol_pkg.sv
hw/rtl/iol_cell.sv
hw/rtl/iol_ctrl.sv
hw/rtl/indexed_ordered_list.sv
test/iol_checker.sv
test/tb.sv
